// ----- hw/rtl/tfn_pkg.sv -----
// Shared types and fixed widths for the triangle face normal pipeline.
// No dependencies.
package tfn_pkg;

   localparam int MAG_BITS  = 30;  // scaled magnitude width
   localparam int SQ_BITS   = 2 * MAG_BITS;
   localparam int SUM_BITS  = 62;  // sum of three squares
   localparam int ROOT_BITS = 31;  // floor(sqrt(sum))
   localparam int FRAC_BITS = 14;  // Q1.14 result
   localparam int Q_BITS    = 15;  // quotient magnitude
   localparam int NUM_BITS  = MAG_BITS + FRAC_BITS + 1;
   localparam int NORM_BITS = 16;

   // Control that travels with every item down the pipeline.
   typedef struct packed {
      logic       valid;
      logic [2:0] neg;
      logic       degen;
   } tfn_tag_type;

endpackage

// ----- hw/rtl/tfn_if.sv -----
// Valid/ready channels for triangles in and normals out.
// Depends on tfn_pkg for the normal width.
interface tfn_req_if #(parameter int COORD_BITS = 24);
   logic valid;
   logic ready;
   logic signed [COORD_BITS-1:0] a_x, a_y, a_z;
   logic signed [COORD_BITS-1:0] b_x, b_y, b_z;
   logic signed [COORD_BITS-1:0] c_x, c_y, c_z;
   modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                   input ready);
   modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                 output ready);
endinterface

interface tfn_rsp_if;
   logic valid;
   logic ready;
   logic signed [tfn_pkg::NORM_BITS-1:0] normal_x, normal_y, normal_z;
   logic degenerate;
   modport source (output valid, normal_x, normal_y, normal_z, degenerate,
                   input ready);
   modport sink (input valid, normal_x, normal_y, normal_z, degenerate,
                 output ready);
endinterface

// ----- hw/rtl/tfn_cross.sv -----
// Edges, six products and the cross product as sign and magnitude.
// Three register stages; depends on tfn_pkg.
module tfn_cross #(
   parameter int COORD_BITS = 24,
   localparam int EW  = COORD_BITS + 1,
   localparam int PW  = 2 * EW,
   localparam int CXW = PW + 1,
   localparam int MW  = 2 * COORD_BITS + 2
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  logic signed [COORD_BITS-1:0] vtx [9],
   output tfn_pkg::tfn_tag_type         tag_out,
   output logic [MW-1:0]                mag_out [3]
);

   logic signed [EW-1:0]  e1_ff [3], e2_ff [3], e1_in [3], e2_in [3];
   logic signed [PW-1:0]  p_ff [6], p_in [6];
   logic signed [CXW-1:0] c_w [3];
   logic [MW-1:0]         mag_ff [3], mag_in [3];
   logic                  v1_ff, v2_ff;
   tfn_pkg::tfn_tag_type  tag_ff, tag_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         e1_in[i] = EW'(vtx[3+i]) - EW'(vtx[i]);
         e2_in[i] = EW'(vtx[6+i]) - EW'(vtx[i]);
      end
      p_in[0] = PW'(e1_ff[1]) * PW'(e2_ff[2]);
      p_in[1] = PW'(e1_ff[2]) * PW'(e2_ff[1]);
      p_in[2] = PW'(e1_ff[2]) * PW'(e2_ff[0]);
      p_in[3] = PW'(e1_ff[0]) * PW'(e2_ff[2]);
      p_in[4] = PW'(e1_ff[0]) * PW'(e2_ff[1]);
      p_in[5] = PW'(e1_ff[1]) * PW'(e2_ff[0]);
      tag_in.valid = v2_ff;
      tag_in.degen = 1'b0;
      for (int i = 0; i < 3; i++) begin
         c_w[i] = CXW'(p_ff[2*i]) - CXW'(p_ff[2*i+1]);
         tag_in.neg[i] = c_w[i][CXW-1];
         mag_in[i] = c_w[i][CXW-1] ? MW'(-c_w[i]) : MW'(c_w[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         tag_ff.valid <= 1'b0;
      end else if (en) begin
         v1_ff  <= in_valid;
         v2_ff  <= v1_ff;
         tag_ff <= tag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e1_ff  <= e1_in;
         e2_ff  <= e2_in;
         p_ff   <= p_in;
         mag_ff <= mag_in;
      end
   end

   assign tag_out = tag_ff;
   assign mag_out = mag_ff;

endmodule

// ----- hw/rtl/tfn_norm.sv -----
// Block scaling to 30 bits, squares and their sum.
// Four register stages; depends on tfn_pkg.
module tfn_norm #(
   parameter int MW = 50,
   localparam int BW = $clog2(MW + 1)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  tfn_pkg::tfn_tag_type           tag_in,
   input  logic [MW-1:0]                  mag_in [3],
   output tfn_pkg::tfn_tag_type           tag_out,
   output logic [tfn_pkg::MAG_BITS-1:0]   m_out [3],
   output logic [tfn_pkg::SUM_BITS-1:0]   sum_out
);

   localparam int MB = tfn_pkg::MAG_BITS;

   logic [MW-1:0]                  or_w;
   logic [BW-1:0]                  b_in, b_ff;
   logic [MW-1:0]                  mag4_ff [3];
   logic [MB-1:0]                  m5_in [3], m5_ff [3], m6_ff [3], m7_ff [3];
   logic [tfn_pkg::SQ_BITS-1:0]    sq_in [3], sq_ff [3];
   logic [tfn_pkg::SUM_BITS-1:0]   sum_in, sum_ff;
   tfn_pkg::tfn_tag_type           t4_in, t4_ff, t5_ff, t6_ff, t7_ff;

   always_comb begin
      or_w = mag_in[0] | mag_in[1] | mag_in[2];
      b_in = '0;
      for (int i = 0; i < MW; i++)
         if (or_w[i]) b_in = BW'(i + 1);
      t4_in       = tag_in;
      t4_in.degen = (or_w == '0);
      // bring the largest magnitude to exactly MB bits, truncating below
      for (int i = 0; i < 3; i++) begin
         if (b_ff > BW'(MB))
            m5_in[i] = MB'(mag4_ff[i] >> (b_ff - BW'(MB)));
         else
            m5_in[i] = MB'(mag4_ff[i] << (BW'(MB) - b_ff));
         sq_in[i] = tfn_pkg::SQ_BITS'(m5_ff[i]) * tfn_pkg::SQ_BITS'(m5_ff[i]);
      end
      sum_in = tfn_pkg::SUM_BITS'(sq_ff[0]) + tfn_pkg::SUM_BITS'(sq_ff[1])
             + tfn_pkg::SUM_BITS'(sq_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t4_ff.valid <= 1'b0;
         t5_ff.valid <= 1'b0;
         t6_ff.valid <= 1'b0;
         t7_ff.valid <= 1'b0;
      end else if (en) begin
         t4_ff <= t4_in;
         t5_ff <= t4_ff;
         t6_ff <= t5_ff;
         t7_ff <= t6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_ff    <= b_in;
         mag4_ff <= mag_in;
         m5_ff   <= m5_in;
         sq_ff   <= sq_in;
         m6_ff   <= m5_ff;
         m7_ff   <= m6_ff;
         sum_ff  <= sum_in;
      end
   end

   assign tag_out = t7_ff;
   assign m_out   = m7_ff;
   assign sum_out = sum_ff;

endmodule

// ----- hw/rtl/tfn_sqrt.sv -----
// Integer square root, one root bit per register stage.
// ROOT_BITS stages; depends on tfn_pkg.
module tfn_sqrt (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  tfn_pkg::tfn_tag_type           tag_in,
   input  logic [tfn_pkg::MAG_BITS-1:0]   m_in [3],
   input  logic [tfn_pkg::SUM_BITS-1:0]   sum_in,
   output tfn_pkg::tfn_tag_type           tag_out,
   output logic [tfn_pkg::MAG_BITS-1:0]   m_out [3],
   output logic [tfn_pkg::ROOT_BITS-1:0]  root_out
);

   localparam int NS = tfn_pkg::ROOT_BITS;
   localparam int RW = tfn_pkg::SUM_BITS;

   logic [RW-1:0]                 rem_ff [NS], rem_in [NS];
   logic [NS-1:0]                 root_ff [NS], root_in [NS];
   logic [tfn_pkg::MAG_BITS-1:0]  m_ff [NS][3], m_src [NS][3];
   tfn_pkg::tfn_tag_type          tag_ff [NS], tag_src [NS];

   always_comb begin
      logic [RW-1:0] rem_s, trial;
      logic [NS-1:0] root_s;
      for (int j = 0; j < NS; j++) begin
         rem_s      = (j == 0) ? sum_in : rem_ff[(j == 0) ? 0 : j-1];
         root_s     = (j == 0) ? '0     : root_ff[(j == 0) ? 0 : j-1];
         tag_src[j] = (j == 0) ? tag_in : tag_ff[(j == 0) ? 0 : j-1];
         m_src[j]   = (j == 0) ? m_in   : m_ff[(j == 0) ? 0 : j-1];
         // (r + 2^k)^2 - r^2 = r*2^(k+1) + 2^(2k)
         trial = (RW'(root_s) << (NS - j)) | (RW'(1) << (2 * (NS - 1 - j)));
         if (rem_s >= trial) begin
            rem_in[j]  = rem_s - trial;
            root_in[j] = root_s | (NS'(1) << (NS - 1 - j));
         end else begin
            rem_in[j]  = rem_s;
            root_in[j] = root_s;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < NS; j++) tag_ff[j].valid <= 1'b0;
      end else if (en) begin
         tag_ff <= tag_src;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         m_ff    <= m_src;
      end
   end

   assign tag_out  = tag_ff[NS-1];
   assign m_out    = m_ff[NS-1];
   assign root_out = root_ff[NS-1];

endmodule

// ----- hw/rtl/tfn_div.sv -----
// Rounded division of each scaled magnitude by the length, one quotient
// bit per stage, then sign and degenerate handling. Depends on tfn_pkg.
module tfn_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  tfn_pkg::tfn_tag_type                tag_in,
   input  logic [tfn_pkg::MAG_BITS-1:0]        m_in [3],
   input  logic [tfn_pkg::ROOT_BITS-1:0]       len_in,
   output logic                                valid_out,
   output logic                                degen_out,
   output logic signed [tfn_pkg::NORM_BITS-1:0] norm_out [3]
);

   localparam int NS = tfn_pkg::Q_BITS;
   localparam int NW = tfn_pkg::NUM_BITS;
   localparam int LW = tfn_pkg::ROOT_BITS;

   logic [NW-1:0]                  rem_ff [NS][3], rem_in [NS][3];
   logic [NS-1:0]                  q_ff [NS][3], q_in [NS][3];
   logic [LW-1:0]                  len_ff [NS], len_src [NS];
   tfn_pkg::tfn_tag_type           tag_ff [NS], tag_src [NS];
   logic signed [tfn_pkg::NORM_BITS-1:0] norm_ff [3], norm_in [3];
   logic                           out_v_ff, out_d_ff;

   always_comb begin
      logic [NW-1:0] rem_s, dvs;
      logic [NS-1:0] q_s;
      for (int j = 0; j < NS; j++) begin
         len_src[j] = (j == 0) ? len_in : len_ff[(j == 0) ? 0 : j-1];
         tag_src[j] = (j == 0) ? tag_in : tag_ff[(j == 0) ? 0 : j-1];
         dvs = NW'(len_src[j]) << (NS - 1 - j);
         for (int i = 0; i < 3; i++) begin
            // numerator m * 2^14 + floor(len / 2) rounds half up
            if (j == 0) begin
               rem_s = (NW'(m_in[i]) << tfn_pkg::FRAC_BITS) + NW'(len_in >> 1);
               q_s   = '0;
            end else begin
               rem_s = rem_ff[(j == 0) ? 0 : j-1][i];
               q_s   = q_ff[(j == 0) ? 0 : j-1][i];
            end
            if (rem_s >= dvs) begin
               rem_in[j][i] = rem_s - dvs;
               q_in[j][i]   = q_s | (NS'(1) << (NS - 1 - j));
            end else begin
               rem_in[j][i] = rem_s;
               q_in[j][i]   = q_s;
            end
         end
      end
      for (int i = 0; i < 3; i++) begin
         if (tag_ff[NS-1].degen)
            norm_in[i] = '0;
         else if (tag_ff[NS-1].neg[i])
            norm_in[i] = -$signed(tfn_pkg::NORM_BITS'(q_ff[NS-1][i]));
         else
            norm_in[i] = $signed(tfn_pkg::NORM_BITS'(q_ff[NS-1][i]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < NS; j++) tag_ff[j].valid <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (en) begin
         tag_ff   <= tag_src;
         out_v_ff <= tag_ff[NS-1].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff   <= rem_in;
         q_ff     <= q_in;
         len_ff   <= len_src;
         norm_ff  <= norm_in;
         out_d_ff <= tag_ff[NS-1].degen;
      end
   end

   assign valid_out = out_v_ff;
   assign degen_out = out_d_ff;
   assign norm_out  = norm_ff;

endmodule

// ----- hw/rtl/triangle_face_normal.sv -----
// Top level of the triangle face normal pipeline.
// Depends on tfn_pkg, tfn_if, tfn_cross, tfn_norm, tfn_sqrt and tfn_div.
//
//   channel  dir  handshake      payload
//   req_ch   in   valid/ready    a_*, b_*, c_* (COORD_BITS, Q11.12)
//   rsp_ch   out  valid/ready    normal_x/y/z (Q1.14), degenerate
//
// One triangle enters per cycle unless the output stalls, then passes 3
// cross-product stages, 4 scaling stages, 31 square-root stages (one root
// bit each), 15 division stages (one quotient bit each), output register.
// Reset clears only the valid bits. When the output holds an item that is
// not taken, every stage holds, so nothing is lost or repeated.
module triangle_face_normal #(
   parameter int COORD_BITS = 24
) (
   input logic       clock,
   input logic       reset,
   tfn_req_if.sink   req_ch,
   tfn_rsp_if.source rsp_ch
);

   localparam int MW = 2 * COORD_BITS + 2;

   logic                                 en, out_valid, out_degen;
   logic signed [COORD_BITS-1:0]         vtx [9];
   tfn_pkg::tfn_tag_type                 cx_tag, nm_tag, sq_tag;
   logic [MW-1:0]                        cx_mag [3];
   logic [tfn_pkg::MAG_BITS-1:0]         nm_m [3], sq_m [3];
   logic [tfn_pkg::SUM_BITS-1:0]         nm_sum;
   logic [tfn_pkg::ROOT_BITS-1:0]        sq_len;
   logic signed [tfn_pkg::NORM_BITS-1:0] norm [3];

   // advance everything unless a finished item waits at the output
   assign en           = !out_valid || rsp_ch.ready;
   assign req_ch.ready = en;

   assign vtx = '{req_ch.a_x, req_ch.a_y, req_ch.a_z,
                  req_ch.b_x, req_ch.b_y, req_ch.b_z,
                  req_ch.c_x, req_ch.c_y, req_ch.c_z};

   tfn_cross #(.COORD_BITS(COORD_BITS)) u_cross (
      .clock, .reset, .en,
      .in_valid (req_ch.valid),
      .vtx      (vtx),
      .tag_out  (cx_tag),
      .mag_out  (cx_mag)
   );

   tfn_norm #(.MW(MW)) u_norm (
      .clock, .reset, .en,
      .tag_in  (cx_tag),
      .mag_in  (cx_mag),
      .tag_out (nm_tag),
      .m_out   (nm_m),
      .sum_out (nm_sum)
   );

   tfn_sqrt u_sqrt (
      .clock, .reset, .en,
      .tag_in   (nm_tag),
      .m_in     (nm_m),
      .sum_in   (nm_sum),
      .tag_out  (sq_tag),
      .m_out    (sq_m),
      .root_out (sq_len)
   );

   tfn_div u_div (
      .clock, .reset, .en,
      .tag_in    (sq_tag),
      .m_in      (sq_m),
      .len_in    (sq_len),
      .valid_out (out_valid),
      .degen_out (out_degen),
      .norm_out  (norm)
   );

   assign rsp_ch.valid      = out_valid;
   assign rsp_ch.normal_x   = norm[0];
   assign rsp_ch.normal_y   = norm[1];
   assign rsp_ch.normal_z   = norm[2];
   assign rsp_ch.degenerate = out_degen;

endmodule
